// ===== design/i2cms_pkg.sv =====
// Shared types and constants for the I2C master byte sequencer.
// No dependencies; used by i2cms_core, i2c_master_byte_sequencer_core and the bench.
`timescale 1ns / 1ps

package i2cms_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;

  localparam logic [4:0] LAST_PHASE_SHORT = 5'd3;
  localparam logic [4:0] LAST_PHASE_WRITE = 5'd27;
  localparam logic [4:0] LAST_PHASE_READ  = 5'd19;

  // Write sequence landmarks
  localparam logic [4:0] WR_DATA_END  = 5'd24;
  localparam logic [4:0] WR_ACK_SCL_L = 5'd24;
  localparam logic [4:0] WR_ACK_SDA   = 5'd25;
  localparam logic [4:0] WR_ACK_SCL_H = 5'd26;

  // Read sequence landmarks
  localparam logic [4:0] RD_SCL_L0   = 5'd0;
  localparam logic [4:0] RD_SDA_REL  = 5'd1;
  localparam logic [4:0] RD_BITS_LO  = 5'd2;
  localparam logic [4:0] RD_ACK_SDA  = 5'd18;

  // One tick of input
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] func;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // One tick of output
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } result_t;

  // Bit number of a write data phase: idx / 3 via reciprocal (exact for idx < 24)
  function automatic logic [2:0] wr_bit_num(input logic [4:0] idx);
    logic [9:0] prod;
    prod = 10'(idx) * 10'd11;
    return prod[7:5];
  endfunction

endpackage

// ===== design/i2cms_core.sv =====
// Sequencer state and single-tick step logic for the I2C master.
// Depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2cms_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  i2cms_pkg::item_t    item,
  input  logic [15:0]         phase_ticks,
  output i2cms_pkg::result_t  result
);

  i2cms_pkg::cmd_t command_latched, command_latched_next;
  logic        active, active_next;
  logic [4:0]  phase_index, phase_index_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  shift_data, shift_data_next;
  logic        ack_to_send, ack_to_send_next;
  logic        scl_out, scl_out_next;
  logic        sda_out, sda_out_next;
  logic        ack_flag, ack_flag_next;
  logic [7:0]  read_result, read_result_next;

  logic [16:0] len;
  logic [4:0]  last_phase;
  logic [2:0]  bit_num;
  logic [4:0]  bit_base;
  logic [4:0]  bit_rem;
  logic        phase_end;
  logic        done;

  always_comb begin
    command_latched_next = command_latched;
    active_next          = active;
    phase_index_next     = phase_index;
    tick_count_next      = tick_count;
    shift_data_next      = shift_data;
    ack_to_send_next     = ack_to_send;
    scl_out_next         = scl_out;
    sda_out_next         = sda_out;
    ack_flag_next        = ack_flag;
    read_result_next     = read_result;
    done                 = 1'b0;
    phase_end            = 1'b0;
    len       = (phase_ticks == 16'd0) ? 17'd1 : {1'b0, phase_ticks};
    last_phase = i2cms_pkg::LAST_PHASE_SHORT;
    bit_num   = 3'd0;
    bit_base  = 5'd0;
    bit_rem   = 5'd0;

    // Latch a new command when idle
    if (!active && item.cmd_valid) begin
      command_latched_next = i2cms_pkg::cmd_t'(item.func);
      active_next          = 1'b1;
      phase_index_next     = 5'd0;
      tick_count_next      = 16'd0;
      ack_to_send_next     = item.send_ack;
      shift_data_next      = (item.func == i2cms_pkg::CMD_WRITE) ? item.write_byte : 8'd0;
    end

    unique case (command_latched_next)
      i2cms_pkg::CMD_WRITE: last_phase = i2cms_pkg::LAST_PHASE_WRITE;
      i2cms_pkg::CMD_READ:  last_phase = i2cms_pkg::LAST_PHASE_READ;
      default:              last_phase = i2cms_pkg::LAST_PHASE_SHORT;
    endcase

    bit_num  = i2cms_pkg::wr_bit_num(phase_index_next);
    bit_base = 5'({2'b00, bit_num} * 5'd3);
    bit_rem  = phase_index_next - bit_base;

    if (active_next) begin
      // Pin update on the first tick of a phase
      if (tick_count_next == 16'd0) begin
        unique case (command_latched_next)
          i2cms_pkg::CMD_START, i2cms_pkg::CMD_STOP: begin
            if (phase_index_next[0]) begin
              sda_out_next = (command_latched_next == i2cms_pkg::CMD_START)
                             ? (phase_index_next[1:0] == 2'd1)
                             : (phase_index_next[1:0] == 2'd3);
            end else begin
              scl_out_next = phase_index_next[1];
            end
          end
          i2cms_pkg::CMD_WRITE: begin
            if (phase_index_next < i2cms_pkg::WR_DATA_END) begin
              if (bit_rem == 5'd0) scl_out_next = 1'b0;
              else if (bit_rem == 5'd1) sda_out_next = shift_data_next[~bit_num];
              else scl_out_next = 1'b1;
            end else if (phase_index_next == i2cms_pkg::WR_ACK_SCL_L) begin
              scl_out_next = 1'b0;
            end else if (phase_index_next == i2cms_pkg::WR_ACK_SDA) begin
              sda_out_next = 1'b1;
            end else if (phase_index_next == i2cms_pkg::WR_ACK_SCL_H) begin
              scl_out_next = 1'b1;
            end else begin
              scl_out_next = 1'b0;
            end
          end
          default: begin
            if (phase_index_next == i2cms_pkg::RD_SCL_L0) scl_out_next = 1'b0;
            else if (phase_index_next == i2cms_pkg::RD_SDA_REL) sda_out_next = 1'b1;
            else if (phase_index_next < i2cms_pkg::RD_ACK_SDA) scl_out_next = ~phase_index_next[0];
            else if (phase_index_next == i2cms_pkg::RD_ACK_SDA) sda_out_next = ~ack_to_send_next;
            else scl_out_next = 1'b1;
          end
        endcase
      end

      phase_end = ({1'b0, tick_count_next} + 17'd1) >= len;
      if (phase_end) begin
        // Sample on the last tick of a phase
        if (command_latched_next == i2cms_pkg::CMD_WRITE &&
            phase_index_next == i2cms_pkg::WR_ACK_SCL_H) begin
          ack_flag_next = ~item.sda_in;
        end else if (command_latched_next == i2cms_pkg::CMD_READ &&
                     phase_index_next >= i2cms_pkg::RD_BITS_LO &&
                     phase_index_next < i2cms_pkg::RD_ACK_SDA &&
                     !phase_index_next[0]) begin
          shift_data_next = {shift_data_next[6:0], item.sda_in};
        end
        tick_count_next = 16'd0;
        if (phase_index_next >= last_phase) begin
          done             = 1'b1;
          active_next      = 1'b0;
          phase_index_next = 5'd0;
          if (command_latched_next == i2cms_pkg::CMD_READ) read_result_next = shift_data_next;
        end else begin
          phase_index_next = phase_index_next + 5'd1;
        end
      end else begin
        tick_count_next = tick_count_next + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_latched <= i2cms_pkg::CMD_START;
      active          <= 1'b0;
      phase_index     <= 5'd0;
      tick_count      <= 16'd0;
      shift_data      <= 8'd0;
      ack_to_send     <= 1'b0;
      scl_out         <= 1'b1;
      sda_out         <= 1'b1;
      ack_flag        <= 1'b0;
      read_result     <= 8'd0;
    end else if (step) begin
      command_latched <= command_latched_next;
      active          <= active_next;
      phase_index     <= phase_index_next;
      tick_count      <= tick_count_next;
      shift_data      <= shift_data_next;
      ack_to_send     <= ack_to_send_next;
      scl_out         <= scl_out_next;
      sda_out         <= sda_out_next;
      ack_flag        <= ack_flag_next;
      read_result     <= read_result_next;
    end
  end

  assign result.scl_level   = scl_out_next;
  assign result.sda_release = sda_out_next;
  assign result.busy_res    = active || (item.cmd_valid && !active);
  assign result.done_res    = done;
  assign result.read_byte   = read_result_next;
  assign result.ack_seen    = ack_flag_next;

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    step && result.done_res |-> result.busy_res)
    else $error("done without busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && result.done_res |=> !active && phase_index == 5'd0)
    else $error("sequence did not return to idle after done");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase_index) && $stable(tick_count) && $stable(active))
    else $error("state moved without a tick");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !active |-> tick_count == 16'd0 && phase_index == 5'd0)
    else $error("idle with nonzero counters");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_index <= i2cms_pkg::LAST_PHASE_WRITE)
    else $error("phase index out of range");

endmodule

// ===== design/i2c_master_byte_sequencer_core.sv =====
// Top level of the I2C master byte sequencer: input word register, step core,
// output word register and the phase length register. Depends on i2cms_pkg, i2cms_core.
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// in       in_valid / in_ready        cmd_valid, func, write_byte, send_ack, sda_in
// out      out_valid / out_ready      scl_level, sda_release, busy_res, done_res,
//                                     read_byte, ack_seen
// cfg      cfg_valid / cfg_ready      cfg_data (phase_ticks)
//
// One input word per clock while the output is not stalled; path: input register, then the
// step logic of i2cms_core feeding the output register.
// Reset (rst, synchronous) idles the sequencer, lines released, phase_ticks = 50.
// An output stall holds the output word and stops the step; in_ready stays high
// while the input register is empty or moving. cfg_ready is always high.

module i2c_master_byte_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd_valid,
  input  logic [1:0]  func,
  input  logic [7:0]  write_byte,
  input  logic        send_ack,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_release,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_byte,
  output logic        ack_seen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic                in_q_valid;
  i2cms_pkg::item_t    in_q;
  i2cms_pkg::result_t  step_res;
  i2cms_pkg::result_t  out_q;
  logic [15:0]         phase_ticks;
  logic                advance;

  assign advance   = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid  <= 1'b0;
      out_valid   <= 1'b0;
      phase_ticks <= i2cms_pkg::PHASE_TICKS_RESET;
    end else begin
      if (in_ready) in_q_valid <= in_valid;
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_valid) phase_ticks <= cfg_data;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.cmd_valid  <= cmd_valid;
      in_q.func       <= func;
      in_q.write_byte <= write_byte;
      in_q.send_ack   <= send_ack;
      in_q.sda_in     <= sda_in;
    end
    if (advance) out_q <= step_res;
  end

  i2cms_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (in_q),
    .phase_ticks (phase_ticks),
    .result      (step_res)
  );

  assign scl_level   = out_q.scl_level;
  assign sda_release = out_q.sda_release;
  assign busy_res    = out_q.busy_res;
  assign done_res    = out_q.done_res;
  assign read_byte   = out_q.read_byte;
  assign ack_seen    = out_q.ack_seen;

endmodule

// ===== bench/i2cms_tick_checker.sv =====
// Tick checker for the I2C master byte sequencer: follows the in, out and cfg
// channels, predicts each output word and compares it. Depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2cms_tick_checker
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd_valid,
  input  logic [1:0]  func,
  input  logic [7:0]  write_byte,
  input  logic        send_ack,
  input  logic        sda_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        scl_level,
  input  logic        sda_release,
  input  logic        busy_res,
  input  logic        done_res,
  input  logic [7:0]  read_byte,
  input  logic        ack_seen,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          results_due,
  output int          cmds_started,
  output logic        seq_busy
);

  // Sequencer image
  logic [15:0] phase_len;
  cmd_t        cur_cmd;
  logic        seq_on;
  logic [4:0]  phase_no;
  logic [15:0] hold_cnt;
  logic [7:0]  byte_shift;
  logic [7:0]  rx_byte;
  logic        ack_drive;
  logic        scl_line;
  logic        sda_line;
  logic        ack_got;

  result_t pin_state_q[$];
  int      mismatches = 0;

  assign fail_count = mismatches;

  task automatic check_field(input string fname, input logic [7:0] want_v, got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", fname, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : predict_and_compare
    result_t      got;
    result_t      want;
    logic [16:0]  span;
    logic [2:0]   bitno;
    logic [4:0]   last_ph;
    if (rst) begin
      phase_len  = PHASE_TICKS_RESET;
      cur_cmd    = CMD_START;
      seq_on     = 1'b0;
      phase_no   = '0;
      hold_cnt   = '0;
      byte_shift = '0;
      rx_byte    = '0;
      ack_drive  = 1'b0;
      scl_line   = 1'b1;
      sda_line   = 1'b1;
      ack_got    = 1'b0;
      pin_state_q.delete();
      results_due  <= 0;
      cmds_started <= 0;
      seq_busy     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        phase_len = cfg_data;
      end

      if (out_valid && out_ready) begin
        got = {scl_level, sda_release, busy_res, done_res, read_byte, ack_seen};
        if (pin_state_q.size() == 0) begin
          $error("output word with nothing expected");
          mismatches++;
        end else begin
          want = pin_state_q.pop_front();
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_release", want.sda_release, got.sda_release);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("ack_seen", want.ack_seen, got.ack_seen);
        end
      end

      if (in_valid && in_ready) begin
        // zero length acts as one tick
        span = (phase_len == '0) ? 17'd1 : {1'b0, phase_len};
        want = '0;
        if (!seq_on && cmd_valid) begin
          cur_cmd    = cmd_t'(func);
          seq_on     = 1'b1;
          phase_no   = '0;
          hold_cnt   = '0;
          ack_drive  = send_ack;
          byte_shift = (cmd_t'(func) == CMD_WRITE) ? write_byte : 8'h00;
          cmds_started <= cmds_started + 1;
        end

        if (seq_on) begin
          want.busy_res = 1'b1;
          case (cur_cmd)
            CMD_WRITE: last_ph = LAST_PHASE_WRITE;
            CMD_READ:  last_ph = LAST_PHASE_READ;
            default:   last_ph = LAST_PHASE_SHORT;
          endcase

          // set the line of this phase on its first tick
          if (hold_cnt == '0) begin
            case (cur_cmd)
              CMD_START, CMD_STOP: begin
                case (phase_no[1:0])
                  2'd0:    scl_line = 1'b0;
                  2'd1:    sda_line = (cur_cmd == CMD_START);
                  2'd2:    scl_line = 1'b1;
                  default: sda_line = (cur_cmd == CMD_STOP);
                endcase
              end
              CMD_WRITE: begin
                if (phase_no < WR_DATA_END) begin
                  bitno = 3'(phase_no / 3);
                  case (phase_no % 3)
                    0:       scl_line = 1'b0;
                    1:       sda_line = byte_shift[3'd7 - bitno];
                    default: scl_line = 1'b1;
                  endcase
                end else if (phase_no == WR_ACK_SDA) begin
                  sda_line = 1'b1;
                end else begin
                  scl_line = (phase_no == WR_ACK_SCL_H);
                end
              end
              default: begin
                if (phase_no == RD_SCL_L0) begin
                  scl_line = 1'b0;
                end else if (phase_no == RD_SDA_REL) begin
                  sda_line = 1'b1;
                end else if (phase_no < RD_ACK_SDA) begin
                  scl_line = ~phase_no[0];
                end else if (phase_no == RD_ACK_SDA) begin
                  sda_line = ~ack_drive;
                end else begin
                  scl_line = 1'b1;
                end
              end
            endcase
          end

          // sample on the last tick of the phase, then advance
          if ({1'b0, hold_cnt} + 17'd1 >= span) begin
            if (cur_cmd == CMD_WRITE && phase_no == WR_ACK_SCL_H) begin
              ack_got = ~sda_in;
            end else if (cur_cmd == CMD_READ && phase_no >= RD_BITS_LO &&
                         phase_no < RD_ACK_SDA && !phase_no[0]) begin
              byte_shift = {byte_shift[6:0], sda_in};
            end
            hold_cnt = '0;
            if (phase_no >= last_ph) begin
              want.done_res = 1'b1;
              seq_on   = 1'b0;
              phase_no = '0;
              if (cur_cmd == CMD_READ) rx_byte = byte_shift;
            end else begin
              phase_no = phase_no + 5'd1;
            end
          end else begin
            hold_cnt = hold_cnt + 16'd1;
          end
        end

        want.scl_level   = scl_line;
        want.sda_release = sda_line;
        want.read_byte   = rx_byte;
        want.ack_seen    = ack_got;
        pin_state_q.push_back(want);
      end

      results_due <= pin_state_q.size();
      seq_busy    <= seq_on;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the I2C master sequencer bench: clock, reset, bus command stimulus,
// phase length changes and the verdict. Depends on i2cms_pkg, i2cms_tick_checker, i2c_master_byte_sequencer_core.
`timescale 1ns / 1ps

module tb_top;
  import i2cms_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_TICKS = 600;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd_valid = 1'b0;
  logic [1:0]  func = CMD_START;
  logic [7:0]  write_byte = '0;
  logic        send_ack = 1'b0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_level;
  logic        sda_release;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_byte;
  logic        ack_seen;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int   fail_count;
  int   results_due;
  int   cmds_started;
  logic seq_busy;

  item_t bus_plan[$];
  int    cmds_seen = 0;
  bit    in_calm = 1'b0;
  bit    out_calm = 1'b0;
  int    stall_cycles = 0;

  i2c_master_byte_sequencer_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd_valid(cmd_valid), .func(func), .write_byte(write_byte),
    .send_ack(send_ack), .sda_in(sda_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .scl_level(scl_level), .sda_release(sda_release), .busy_res(busy_res),
    .done_res(done_res), .read_byte(read_byte), .ack_seen(ack_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  i2cms_tick_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd_valid(cmd_valid), .func(func), .write_byte(write_byte),
    .send_ack(send_ack), .sda_in(sda_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .scl_level(scl_level), .sda_release(sda_release), .busy_res(busy_res),
    .done_res(done_res), .read_byte(read_byte), .ack_seen(ack_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_due(results_due),
    .cmds_started(cmds_started), .seq_busy(seq_busy)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(15);
  endfunction

  function automatic void plan_cmd(input cmd_t c, input logic [7:0] b, input logic ack);
    item_t w;
    w.cmd_valid  = 1'b1;
    w.func       = c;
    w.write_byte = b;
    w.send_ack   = ack;
    w.sda_in     = 1'b1;
    bus_plan.push_back(w);
  endfunction

  // One bus transfer: start, address, data bytes, optional repeated start, stop.
  // A few are loose command strings instead.
  function automatic void queue_transfer();
    logic [7:0] addr;
    int         n;
    if ($urandom_range(9) < 2) begin
      n = $urandom_range(1, 3);
      repeat (n) plan_cmd(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
    end else begin
      addr = 8'($urandom);
      n = $urandom_range(1, 4);
      plan_cmd(CMD_START, 8'($urandom), 1'($urandom));
      plan_cmd(CMD_WRITE, addr, 1'($urandom));
      for (int k = 0; k < n; k++) begin
        if (addr[0]) plan_cmd(CMD_READ, 8'($urandom), (k != n - 1) ^ ($urandom_range(7) == 0));
        else plan_cmd(CMD_WRITE, 8'($urandom), 1'($urandom));
      end
      if ($urandom_range(3) == 0) begin
        plan_cmd(CMD_START, 8'($urandom), 1'($urandom));
        plan_cmd(CMD_WRITE, addr | 8'h01, 1'($urandom));
        plan_cmd(CMD_READ, 8'($urandom), 1'b0);
      end
      plan_cmd(CMD_STOP, 8'($urandom), 1'($urandom));
    end
  endfunction

  // Offer the head of the plan; the block ignores it while busy. The started
  // count lags one word, so the head shows once more after it was taken.
  task automatic next_word(output item_t w);
    if (cmds_started != cmds_seen) begin
      cmds_seen = cmds_started;
      if (bus_plan.size() != 0) void'(bus_plan.pop_front());
    end
    w.cmd_valid  = 1'b0;
    w.func       = 2'($urandom);
    w.write_byte = 8'($urandom);
    w.send_ack   = 1'($urandom);
    if (bus_plan.size() != 0 && $urandom_range(3) != 0) w = bus_plan[0];
    w.sda_in = 1'($urandom);
  endtask

  task automatic send_word(input item_t w);
    int gap;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd_valid  <= w.cmd_valid;
    func       <= w.func;
    write_byte <= w.write_byte;
    send_ack   <= w.send_ack;
    sda_in     <= w.sda_in;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_ticks(input int n);
    item_t w;
    repeat (n) begin
      next_word(w);
      send_word(w);
    end
  endtask

  task automatic run_plan();
    item_t w;
    do begin
      next_word(w);
      send_word(w);
    end while (bus_plan.size() != 0 || seq_busy);
  endtask

  task automatic hold_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic retune(input logic [15:0] len);
    hold_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall a random number of cycles before each word
  initial begin : drain_side
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(47) == 0) out_calm = !out_calm;
      gap = pick_gap(out_calm);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int ticks;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset phase length: one start condition
    plan_cmd(CMD_START, 8'h00, 1'b0);
    run_plan();

    retune(16'd1);
    plan_cmd(CMD_START, 8'h00, 1'b0);
    plan_cmd(CMD_WRITE, 8'hFF, 1'b0);
    plan_cmd(CMD_WRITE, 8'h00, 1'b1);
    plan_cmd(CMD_WRITE, 8'hA5, 1'b0);
    plan_cmd(CMD_READ, 8'h00, 1'b1);
    plan_cmd(CMD_READ, 8'hFF, 1'b0);
    plan_cmd(CMD_STOP, 8'h00, 1'b0);
    run_plan();

    // zero length behaves as one tick; stray stop and read out of frame
    retune(16'd0);
    plan_cmd(CMD_START, 8'h00, 1'b1);
    plan_cmd(CMD_WRITE, 8'h5A, 1'b1);
    plan_cmd(CMD_READ, 8'h00, 1'b1);
    plan_cmd(CMD_STOP, 8'h00, 1'b0);
    plan_cmd(CMD_STOP, 8'hFF, 1'b1);
    plan_cmd(CMD_READ, 8'hFF, 1'b0);
    run_plan();

    // longest phase, then shrink it mid-phase so the phase ends at once
    retune(16'hFFFF);
    plan_cmd(CMD_WRITE, 8'h3C, 1'b0);
    run_ticks(100);
    retune(16'd2);
    run_plan();

    ticks = 0;
    while (ticks < RANDOM_TICKS) begin
      if (bus_plan.size() == 0) queue_transfer();
      run_ticks(1);
      ticks++;
      if ($urandom_range(63) == 0) in_calm = !in_calm;
      if (ticks % 300 == 150) begin
        hold_for_results();
      end else if (ticks % 300 == 299) begin
        case ($urandom_range(4))
          0:       retune(16'd0);
          1:       retune(16'd1);
          2:       retune(16'd3);
          default: retune(16'($urandom_range(1, 5)));
        endcase
      end
    end
    run_plan();

    hold_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
